@@ src/lat_lon_to_sphere_xyz_macros.svh @@
// Assertion macros used by the checker of the sphere point converter
`ifndef LAT_LON_TO_SPHERE_XYZ_MACROS_SVH
`define LAT_LON_TO_SPHERE_XYZ_MACROS_SVH

// plain property, clocked and held off during reset
`define LLSXYZ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition in this cycle implies result in the next
`define LLSXYZ_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ src/llsxyz_pkg.sv @@
// Constants, types and helper functions of the sphere point converter
`default_nettype none

package llsxyz_pkg;

    localparam int CORDIC_STAGES_DEF = 16;

    localparam int AW   = 18;   // angle after widening, 1/256 degree
    localparam int ZW   = 25;   // residual angle, 2^-16 degree
    localparam int XW   = 32;   // CORDIC x/y, Q30
    localparam int FRAC = 30;
    localparam int RW   = 16;   // radius, Q1.15 unsigned
    localparam int OW   = 17;   // outputs, Q1.15 signed
    localparam int MW   = XW + RW + 1;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 56;

    localparam logic [RW-1:0] RADIUS_RESET = 16'd32768;

    localparam logic signed [XW-1:0] CORDIC_GAIN = 32'sd652032874;

    localparam logic signed [AW-1:0] HALF_TURN    = 18'sd46080;
    localparam logic signed [AW-1:0] FULL_TURN    = 18'sd92160;
    localparam logic signed [AW-1:0] QUARTER_TURN = 18'sd23040;

    localparam logic signed [2*XW-1:0] RND_P = (2*XW)'(1 << (FRAC - 1));
    localparam logic signed [MW-1:0]   RND_M = MW'(1 << (FRAC - 1));

    localparam logic signed [MW-FRAC-1:0] Q_MAX = 19'sd65535;
    localparam logic signed [MW-FRAC-1:0] Q_MIN = -19'sd65536;

    typedef struct packed {
        logic                 neg;
        logic signed [ZW-1:0] z;
    } fold_t;

    // atan(2^-i) in degrees, 2^-16 degree units
    function automatic logic signed [ZW-1:0] atan_q16(input int idx);
        logic signed [ZW-1:0] v;
        case (idx)
            0:       v = 25'sd2949120;
            1:       v = 25'sd1740967;
            2:       v = 25'sd919879;
            3:       v = 25'sd466945;
            4:       v = 25'sd234379;
            5:       v = 25'sd117304;
            6:       v = 25'sd58666;
            7:       v = 25'sd29335;
            8:       v = 25'sd14668;
            9:       v = 25'sd7334;
            10:      v = 25'sd3667;
            11:      v = 25'sd1833;
            12:      v = 25'sd917;
            13:      v = 25'sd458;
            14:      v = 25'sd229;
            15:      v = 25'sd115;
            16:      v = 25'sd57;
            17:      v = 25'sd29;
            18:      v = 25'sd14;
            19:      v = 25'sd7;
            20:      v = 25'sd4;
            21:      v = 25'sd2;
            22:      v = 25'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    // wrap into [-180,180), mirror beyond +-90 (cosine then negated)
    function automatic fold_t fold_angle(input logic signed [AW-1:0] a_in);
        logic signed [AW-1:0] a;
        fold_t                f;
        a = a_in;
        if (a >= HALF_TURN)
        begin
            a = a - FULL_TURN;
        end
        else if (a < -HALF_TURN)
        begin
            a = a + FULL_TURN;
        end
        f.neg = 1'b0;
        if (a > QUARTER_TURN)
        begin
            a     = HALF_TURN - a;
            f.neg = 1'b1;
        end
        else if (a < -QUARTER_TURN)
        begin
            a     = -HALF_TURN - a;
            f.neg = 1'b1;
        end
        f.z = {a[ZW-9:0], 8'b0};
        return f;
    endfunction

    // Q45 -> Q15 with rounding, saturated to the output range
    function automatic logic signed [OW-1:0] sat_q15(input logic signed [MW-1:0] m);
        logic signed [MW-1:0]      s;
        logic signed [MW-FRAC-1:0] q;
        s = m + RND_M;
        q = s[MW-1:FRAC];
        if (q > Q_MAX)
        begin
            q = Q_MAX;
        end
        else if (q < Q_MIN)
        begin
            q = Q_MIN;
        end
        return q[OW-1:0];
    endfunction

endpackage

`default_nettype wire

@@ src/lat_lon_to_sphere_xyz.sv @@
// Latitude/longitude to point on a sphere, two unrolled CORDICs and a multiply tail
// Throughput: one word per cycle while m_tready is high; each stage has its own valid and ready,
// so bubbles fill while the output register waits.
// Reset: all valid bits clear, radius returns to 1.0 (32768).
`default_nettype none

module lat_lon_to_sphere_xyz
    import llsxyz_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [RW-1:0]          cfg_data,    // radius
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,     // lat_deg[15:0], lon_deg[32:16]
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata      // pos_x[16:0], pos_y[33:17], pos_z[50:34]
);

    localparam int NS    = CORDIC_STAGES + 5;
    localparam int S_NEG = CORDIC_STAGES + 1;
    localparam int S_MUL = CORDIC_STAGES + 2;
    localparam int S_RAD = CORDIC_STAGES + 3;
    localparam int S_OUT = CORDIC_STAGES + 4;

    logic [RW-1:0] radius_reg;

    logic [NS-1:0] ce;
    logic [NS-1:0] v_reg;
    logic [NS-1:0] v_next;

    logic signed [15:0] lat_deg;
    logic signed [16:0] lon_deg;

    fold_t fl_reg;
    fold_t fn_reg;

    logic signed [XW-1:0] xl_reg [1:CORDIC_STAGES];
    logic signed [XW-1:0] yl_reg [1:CORDIC_STAGES];
    logic signed [ZW-1:0] zl_reg [1:CORDIC_STAGES];
    logic                 nl_reg [1:CORDIC_STAGES];
    logic signed [XW-1:0] xn_reg [1:CORDIC_STAGES];
    logic signed [XW-1:0] yn_reg [1:CORDIC_STAGES];
    logic signed [ZW-1:0] zn_reg [1:CORDIC_STAGES];
    logic                 nn_reg [1:CORDIC_STAGES];

    logic signed [XW-1:0] cl_reg, sl_reg, cn_reg, sn_reg;
    logic signed [2*XW-1:0] pxx, pxz, pxx_r, pxz_r;
    logic signed [XW-1:0] fx_reg, fy_reg, fz_reg;
    logic signed [RW:0]   rad_s;
    logic signed [MW-1:0] mx_reg, my_reg, mz_reg;
    logic signed [OW-1:0] px_reg, py_reg, pz_reg;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
        end
        else if (cfg_valid)
        begin
            radius_reg <= cfg_data;
        end
    end

    // per-stage flow control
    assign ce[NS-1] = !v_reg[NS-1] || m_tready;

    for (genvar k = 0; k < NS - 1; k++)
    begin : g_ce
        assign ce[k] = !v_reg[k] || ce[k+1];
    end

    assign v_next   = (v_reg & ~ce) | ({v_reg[NS-2:0], s_tvalid} & ce);
    assign s_tready = ce[0];
    assign m_tvalid = v_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    // stage 0: range reduction
    assign lat_deg = s_tdata[15:0];
    assign lon_deg = s_tdata[32:16];

    always_ff @(posedge clk)
    begin
        if (ce[0])
        begin
            fl_reg <= fold_angle(AW'(lat_deg));
            fn_reg <= fold_angle(AW'(lon_deg));
        end
    end

    // CORDIC rotation stages, iteration k-1 in stage k
    for (genvar k = 1; k <= CORDIC_STAGES; k++)
    begin : g_cordic
        logic signed [XW-1:0] xl_in, yl_in, xn_in, yn_in;
        logic signed [ZW-1:0] zl_in, zn_in;
        logic                 nl_in, nn_in;

        if (k == 1)
        begin : g_first
            assign xl_in = CORDIC_GAIN;
            assign yl_in = '0;
            assign zl_in = fl_reg.z;
            assign nl_in = fl_reg.neg;
            assign xn_in = CORDIC_GAIN;
            assign yn_in = '0;
            assign zn_in = fn_reg.z;
            assign nn_in = fn_reg.neg;
        end
        else
        begin : g_rest
            assign xl_in = xl_reg[k-1];
            assign yl_in = yl_reg[k-1];
            assign zl_in = zl_reg[k-1];
            assign nl_in = nl_reg[k-1];
            assign xn_in = xn_reg[k-1];
            assign yn_in = yn_reg[k-1];
            assign zn_in = zn_reg[k-1];
            assign nn_in = nn_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (ce[k])
            begin
                nl_reg[k] <= nl_in;
                nn_reg[k] <= nn_in;
                if (!zl_in[ZW-1])
                begin
                    xl_reg[k] <= xl_in - (yl_in >>> (k - 1));
                    yl_reg[k] <= yl_in + (xl_in >>> (k - 1));
                    zl_reg[k] <= zl_in - atan_q16(k - 1);
                end
                else
                begin
                    xl_reg[k] <= xl_in + (yl_in >>> (k - 1));
                    yl_reg[k] <= yl_in - (xl_in >>> (k - 1));
                    zl_reg[k] <= zl_in + atan_q16(k - 1);
                end
                if (!zn_in[ZW-1])
                begin
                    xn_reg[k] <= xn_in - (yn_in >>> (k - 1));
                    yn_reg[k] <= yn_in + (xn_in >>> (k - 1));
                    zn_reg[k] <= zn_in - atan_q16(k - 1);
                end
                else
                begin
                    xn_reg[k] <= xn_in + (yn_in >>> (k - 1));
                    yn_reg[k] <= yn_in - (xn_in >>> (k - 1));
                    zn_reg[k] <= zn_in + atan_q16(k - 1);
                end
            end
        end
    end

    // cosine sign fix-up
    always_ff @(posedge clk)
    begin
        if (ce[S_NEG])
        begin
            cl_reg <= nl_reg[CORDIC_STAGES] ? -xl_reg[CORDIC_STAGES] : xl_reg[CORDIC_STAGES];
            cn_reg <= nn_reg[CORDIC_STAGES] ? -xn_reg[CORDIC_STAGES] : xn_reg[CORDIC_STAGES];
            sl_reg <= yl_reg[CORDIC_STAGES];
            sn_reg <= yn_reg[CORDIC_STAGES];
        end
    end

    // cos(lat) times cos/sin(lon), rounded to Q30
    assign pxx   = cl_reg * cn_reg;
    assign pxz   = cl_reg * sn_reg;
    assign pxx_r = pxx + RND_P;
    assign pxz_r = pxz + RND_P;

    always_ff @(posedge clk)
    begin
        if (ce[S_MUL])
        begin
            fx_reg <= pxx_r[FRAC+XW-1:FRAC];
            fz_reg <= pxz_r[FRAC+XW-1:FRAC];
            fy_reg <= sl_reg;
        end
    end

    // radius scaling
    assign rad_s = $signed({1'b0, radius_reg});

    always_ff @(posedge clk)
    begin
        if (ce[S_RAD])
        begin
            mx_reg <= fx_reg * rad_s;
            my_reg <= fy_reg * rad_s;
            mz_reg <= fz_reg * rad_s;
        end
    end

    // round and saturate into the output register
    always_ff @(posedge clk)
    begin
        if (ce[S_OUT])
        begin
            px_reg <= sat_q15(mx_reg);
            py_reg <= sat_q15(my_reg);
            pz_reg <= sat_q15(mz_reg);
        end
    end

    assign m_tdata = {{(OUT_TDATA_W - 3*OW){1'b0}}, pz_reg, py_reg, px_reg};

endmodule

`default_nettype wire

@@ src/llsxyz_chk.sv @@
// Port-level checker for the sphere point converter, with its bind
`default_nettype none

`include "lat_lon_to_sphere_xyz_macros.svh"

module llsxyz_chk
    import llsxyz_pkg::*;
#(
    parameter int DEPTH = CORDIC_STAGES_DEF + 5
)
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   s_tvalid,
    input wire logic                   s_tready,
    input wire logic                   m_tvalid,
    input wire logic                   m_tready,
    input wire logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int CW = $clog2(DEPTH + 2);

    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;

    // words accepted but not yet delivered
    assign cnt_next = cnt_reg + CW'(s_tvalid && s_tready) - CW'(m_tvalid && m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    `LLSXYZ_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid,
        "output word dropped while stalled")
    `LLSXYZ_ASSERT_NEXT(a_out_stable, clk, rst_n, m_tvalid && !m_tready, $stable(m_tdata),
        "output word changed while stalled")
    `LLSXYZ_ASSERT(a_no_phantom, clk, rst_n, m_tvalid |-> (cnt_reg != '0),
        "output word with no input word in flight")
    `LLSXYZ_ASSERT(a_depth, clk, rst_n, cnt_reg <= CW'(DEPTH),
        "more words in flight than pipeline stages")

endmodule

bind lat_lon_to_sphere_xyz llsxyz_chk #(
    .DEPTH(CORDIC_STAGES + 5)
) u_llsxyz_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
